### sv/vdri_pkg.sv
// Package: shared types and constants of the varint delta run intersect block.
`default_nettype none
package vdri_pkg;

  localparam logic       KIND_APPEND = 1'b0;
  localparam logic       KIND_BYTE   = 1'b1;
  localparam logic [2:0] MAX_VB      = 3'd5;
  localparam int         QDEPTH      = 4;
  localparam int         QAW         = 2;
  localparam int         QCW         = 3;
  localparam int         MCW         = 13;
  localparam logic [MCW-1:0] COUNT_MAX = 13'h1FFF;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_PROBE,
    OP_END
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] word;
    logic        last;
  } cmd_t;

endpackage
`default_nettype wire

### sv/vdri_if.sv
// Interfaces: input item channel and result channel.
`default_nettype none
interface vdri_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] data;
  logic        last;

  modport source (output valid, output kind, output data, output last, input ready);
  modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

interface vdri_out_if;
  logic        valid;
  logic        ready;
  logic        has_match;
  logic [31:0] match_id;
  logic        done_res;
  logic [12:0] match_count;

  modport source (output valid, output has_match, output match_id, output done_res,
                  output match_count, input ready);
  modport sink   (input valid, input has_match, input match_id, input done_res,
                  input match_count, output ready);
endinterface
`default_nettype wire

### sv/vdri_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module vdri_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### sv/vdri_front.sv
// Front end: accepts items, decodes varint bytes and queues commands.
`default_nettype none
module vdri_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  vdri_in_if.sink             in_ch,
  input  wire logic           q_full,
  output logic                push,
  output vdri_pkg::cmd_t      push_cmd
);
  import vdri_pkg::*;

  logic [31:0] acc_r;
  logic [2:0]  idx_r;
  logic [31:0] add;
  logic [31:0] acc_nxt;
  logic [2:0]  idx_nxt;
  logic [6:0]  pay;
  logic        cont;
  logic        accept;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pay         = in_ch.data[6:0];
  assign cont        = in_ch.data[7];

  always_comb begin
    unique case (idx_r)
      3'd0:    add = {25'b0, pay};
      3'd1:    add = {18'b0, pay, 7'b0};
      3'd2:    add = {11'b0, pay, 14'b0};
      3'd3:    add = {4'b0, pay, 21'b0};
      3'd4:    add = {pay[3:0], 28'b0};
      default: add = '0;
    endcase
  end

  assign acc_nxt = acc_r + add;
  assign idx_nxt = (idx_r < MAX_VB) ? idx_r + 3'd1 : idx_r;

  assign push = accept && (in_ch.kind == KIND_APPEND || !cont || in_ch.last);

  always_comb begin
    push_cmd.word = acc_nxt;
    push_cmd.last = 1'b0;
    if (in_ch.kind == KIND_APPEND) begin
      push_cmd.op   = OP_APPEND;
      push_cmd.word = in_ch.data;
    end else begin
      push_cmd.op   = cont ? OP_END : OP_PROBE;
      push_cmd.last = in_ch.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      idx_r <= '0;
    end else if (accept && in_ch.kind == KIND_BYTE) begin
      if (!cont || in_ch.last) begin
        acc_r <= '0;
        idx_r <= '0;
      end else begin
        acc_r <= acc_nxt;
        idx_r <= idx_nxt;
      end
    end
  end

endmodule
`default_nettype wire

### sv/vdri_fifo.sv
// Command queue between front end and back end.
`default_nettype none
module vdri_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire vdri_pkg::cmd_t din,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output vdri_pkg::cmd_t      dout
);
  import vdri_pkg::*;

  cmd_t           q_r [QDEPTH];
  logic [QAW-1:0] wr_r;
  logic [QAW-1:0] rd_r;
  logic [QCW-1:0] cnt_r;

  assign full      = (cnt_r == QCW'(QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign dout      = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + QAW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + QAW'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QCW'(1);
        2'b01:   cnt_r <= cnt_r - QCW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/vdri_back.sv
// Back end: id store, pointer walk over the store, match count and result register.
`default_nettype none
module vdri_back #(
  parameter int STORE_DEPTH = 4096
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_data,
  input  wire logic [31:0]    start_prev,
  input  wire logic           cmd_valid,
  input  wire vdri_pkg::cmd_t cmd,
  output logic                pop,
  vdri_out_if.source          out_ch
);
  import vdri_pkg::*;

  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int AW = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_FIN
  } state_t;

  state_t         state_r;
  logic [CW-1:0]  cnt_r;
  logic [CW-1:0]  ptr_r;
  logic [31:0]    prev_r;
  logic [31:0]    id_r;
  logic           last_r;
  logic           hit_r;
  logic [MCW-1:0] matches_r;
  logic           out_valid_r;
  logic           out_hit_r;
  logic [31:0]    out_id_r;
  logic           out_done_r;
  logic [MCW-1:0] out_count_r;
  logic           ram_we;
  logic           out_load;
  logic [31:0]    entry;

  assign pop      = (state_r == S_IDLE) && cmd_valid;
  assign ram_we   = pop && cmd.op == OP_APPEND && cnt_r < CW'(STORE_DEPTH);
  assign out_load = (state_r == S_FIN) && (hit_r || last_r) && (!out_valid_r || out_ch.ready);

  vdri_ram #(
    .WIDTH (32),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[AW-1:0]),
    .wdata (cmd.word),
    .re    (state_r == S_READ),
    .raddr (ptr_r[AW-1:0]),
    .rdata (entry)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.has_match   = out_hit_r;
  assign out_ch.match_id    = out_id_r;
  assign out_ch.done_res    = out_done_r;
  assign out_ch.match_count = out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ptr_r       <= '0;
      prev_r      <= '1;
      matches_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        prev_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.op)
              OP_APPEND: begin
                if (cnt_r < CW'(STORE_DEPTH)) begin
                  cnt_r <= cnt_r + CW'(1);
                end
              end
              OP_PROBE: begin
                id_r    <= prev_r + cmd.word + 32'd1;
                last_r  <= cmd.last;
                hit_r   <= 1'b0;
                state_r <= S_READ;
              end
              OP_END: begin
                last_r  <= 1'b1;
                hit_r   <= 1'b0;
                state_r <= S_FIN;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          state_r <= (ptr_r < cnt_r) ? S_CMP : S_FIN;
        end
        S_CMP: begin
          if (id_r < entry) begin
            prev_r  <= id_r;
            state_r <= S_FIN;
          end else begin
            ptr_r <= ptr_r + CW'(1);
            if (id_r == entry) begin
              prev_r  <= id_r;
              hit_r   <= 1'b1;
              state_r <= S_FIN;
              if (matches_r != COUNT_MAX) begin
                matches_r <= matches_r + MCW'(1);
              end
            end else begin
              state_r <= S_READ;
            end
          end
        end
        S_FIN: begin
          if (!hit_r && !last_r) begin
            state_r <= S_IDLE;
          end else if (out_load) begin
            out_hit_r   <= hit_r;
            out_id_r    <= hit_r ? id_r : '0;
            out_done_r  <= last_r;
            out_count_r <= last_r ? matches_r : '0;
            if (last_r) begin
              cnt_r     <= '0;
              ptr_r     <= '0;
              prev_r    <= start_prev;
              matches_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### sv/varint_delta_run_intersect.sv
// Top level: sorted id store intersected with a varint delta coded byte run.
// Front end: one item per cycle while the queue is not full. Back end: one append per cycle;
// a finished id steps through the registered store read and a compare for each store entry
// passed, to a match, a larger entry or the store end, plus any wait on the result register;
// an unfinished final byte skips the store walk. The back end takes no command until idle.
// Sync reset (rst_n low): store and queue empty, varint and match state clear, start id ones.
`default_nettype none
module varint_delta_run_intersect #(
  parameter int STORE_DEPTH = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  vdri_in_if.sink          in_ch,
  vdri_out_if.source       out_ch
);
  import vdri_pkg::*;

  logic [31:0] cfg_start_r;
  logic        push;
  cmd_t        push_cmd;
  logic        q_full;
  logic        pop;
  logic        q_valid;
  cmd_t        q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_start_r <= '1;
    end else if (cfg_we) begin
      cfg_start_r <= cfg_data;
    end
  end

  vdri_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  vdri_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (push_cmd),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .dout      (q_cmd)
  );

  vdri_back #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .start_prev (cfg_start_r),
    .cmd_valid  (q_valid),
    .cmd        (q_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.has_match || out_ch.done_res))
    else $error("result with neither match nor done");

  a_id_zero_without_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.has_match) |-> (out_ch.match_id == 32'd0))
    else $error("match id set without match");

  a_count_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.done_res) |-> (out_ch.match_count == 13'd0))
    else $error("match count set on a result that is not done");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !push)
    else $error("command pushed into a full queue");

endmodule
`default_nettype wire
